### design/stffo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stffo_pkg
// Shared types and constants of the slot table with first-free allocation
// and oldest-date search.
// ----------------------------------------------------------------------------
package stffo_pkg;

    localparam int SlotsDef = 32;
    localparam int OpW      = 3;
    localparam int SlotNumW = 6;
    localparam int YearW    = 14;
    localparam int MonthW   = 4;
    localparam int DayW     = 5;
    localparam int DateW    = YearW + MonthW + DayW;
    localparam int StatusW  = 2;
    localparam int CountW   = 6;

    typedef enum logic [OpW-1:0] {
        OP_SET    = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_FREE   = 3'd4,
        OP_OLDEST = 3'd5
    } t_op;

    typedef enum logic [StatusW-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_SLOT = 2'd1,
        STAT_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // search wavefront handed from cell to cell
    typedef struct packed {
        logic                found;
        logic [DateW-1:0]    best_date;
        logic [SlotNumW-1:0] best_slot;
        logic                free_found;
        logic [SlotNumW-1:0] free_slot;
    } t_scan;

    // table update broadcast to every cell
    typedef struct packed {
        logic                wr;
        logic                del;
        logic                clr;
        logic [SlotNumW-1:0] slot;
        logic [DateW-1:0]    date;
    } t_cmd;

    typedef struct packed {
        logic              busy;
        logic [CountW-1:0] count;
    } t_ctrl_stat;

endpackage
`default_nettype wire

### design/stffo_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stffo_cell
// One table slot: holds its valid bit and date, applies broadcast updates and
// advances the first-free / oldest search wavefront by one position.
// ----------------------------------------------------------------------------
module stffo_cell #(
    parameter logic [5:0] CELL_NUM = 6'd1
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  stffo_pkg::t_cmd  i_cmd,
    input  stffo_pkg::t_scan i_scan,
    output stffo_pkg::t_scan o_scan,
    output logic             o_valid
);
    import stffo_pkg::*;

    logic             r_valid;
    logic [DateW-1:0] r_date;
    t_scan            r_scan;
    t_scan            n_scan;
    logic             w_hit;

    assign w_hit = (i_cmd.slot == CELL_NUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clr) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr && w_hit) begin
            r_valid <= 1'b1;
        end else if (i_cmd.del && w_hit) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_hit) begin
            r_date <= i_cmd.date;
        end
    end

    always_comb begin
        n_scan = i_scan;
        if (r_valid && (!i_scan.found || (r_date < i_scan.best_date))) begin
            n_scan.found     = 1'b1;
            n_scan.best_date = r_date;
            n_scan.best_slot = CELL_NUM;
        end
        if (!i_scan.free_found && !r_valid) begin
            n_scan.free_found = 1'b1;
            n_scan.free_slot  = CELL_NUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan  = r_scan;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

### design/stffo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stffo_ctrl
// Operation sequencer: decodes transactions, keeps the occupied count, waits
// for the search wavefront to leave the chain and holds the result register.
// ----------------------------------------------------------------------------
module stffo_ctrl #(
    parameter int SLOTS = stffo_pkg::SlotsDef
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [stffo_pkg::OpW-1:0]      i_operation,
    input  wire  [stffo_pkg::SlotNumW-1:0] i_slot_number,
    input  wire  [stffo_pkg::DateW-1:0]    i_key,
    input  wire  [SLOTS-1:0]               i_valid_vec,
    input  stffo_pkg::t_scan               i_tail,
    output stffo_pkg::t_cmd                o_cmd,
    output stffo_pkg::t_ctrl_stat          o_stat,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [stffo_pkg::StatusW-1:0]  o_status,
    output logic [stffo_pkg::SlotNumW-1:0] o_result_slot,
    output logic                           o_slot_is_free,
    output logic [stffo_pkg::CountW-1:0]   o_occupied_count
);
    import stffo_pkg::*;

    localparam int         IdxW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [6:0] SlotsLim = 7'(SLOTS);
    localparam logic [IdxW-1:0] CntLast = IdxW'(SLOTS - 1);

    t_state              r_state, n_state;
    logic [IdxW-1:0]     r_cnt, n_cnt;
    logic                r_is_insert, n_is_insert;
    logic [DateW-1:0]    r_key, n_key;
    logic [CountW-1:0]   r_count, n_count;
    logic                r_out_valid, n_out_valid;
    logic [StatusW-1:0]  r_status, n_status;
    logic [SlotNumW-1:0] r_rslot, n_rslot;
    logic                r_free, n_free;

    logic                w_accept;
    logic                w_num_ok;
    logic [SlotNumW-1:0] w_num_m1;
    logic [IdxW-1:0]     w_idx;
    logic                w_cur_valid;
    logic                w_load;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_num_ok    = (i_slot_number != '0) && ({1'b0, i_slot_number} <= SlotsLim);
    assign w_num_m1    = i_slot_number - SlotNumW'(1);
    assign w_idx       = w_num_m1[IdxW-1:0];
    assign w_cur_valid = i_valid_vec[w_idx];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && ((i_operation == OP_INSERT) || (i_operation == OP_OLDEST))) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CntLast) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_cmd       = '0;
        n_cnt       = r_cnt;
        n_is_insert = r_is_insert;
        n_key       = r_key;
        n_count     = r_count;
        n_status    = r_status;
        n_rslot     = r_rslot;
        n_free      = r_free;
        w_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cnt       = '0;
                    n_is_insert = (i_operation == OP_INSERT);
                    n_key       = i_key;
                    n_status    = STAT_OK;
                    n_rslot     = '0;
                    n_free      = 1'b0;
                    w_load      = 1'b1;
                    unique case (i_operation) inside
                        OP_SET: begin
                            if (!w_num_ok) begin
                                n_status = STAT_BAD_SLOT;
                            end else begin
                                o_cmd.wr   = 1'b1;
                                o_cmd.slot = i_slot_number;
                                o_cmd.date = i_key;
                                if (!w_cur_valid) begin
                                    n_count = r_count + CountW'(1);
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (!w_num_ok) begin
                                n_status = STAT_BAD_SLOT;
                            end else if (w_cur_valid) begin
                                o_cmd.del  = 1'b1;
                                o_cmd.slot = i_slot_number;
                                n_count    = r_count - CountW'(1);
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.clr = 1'b1;
                            n_count   = '0;
                        end
                        OP_FREE: begin
                            if (!w_num_ok) begin
                                n_status = STAT_BAD_SLOT;
                            end else begin
                                n_free = !w_cur_valid;
                            end
                        end
                        OP_INSERT, OP_OLDEST: begin
                            w_load = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + IdxW'(1);
            end
            ST_DONE: begin
                w_load   = 1'b1;
                n_status = STAT_OK;
                n_rslot  = '0;
                n_free   = 1'b0;
                if (r_is_insert) begin
                    if (i_tail.free_found) begin
                        o_cmd.wr   = 1'b1;
                        o_cmd.slot = i_tail.free_slot;
                        o_cmd.date = r_key;
                        n_count    = r_count + CountW'(1);
                        n_rslot    = i_tail.free_slot;
                    end else begin
                        n_status = STAT_FULL;
                    end
                end else begin
                    n_rslot = i_tail.best_slot;
                end
            end
            default: begin
            end
        endcase
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_insert <= n_is_insert;
        r_key       <= n_key;
        if (w_load) begin
            r_status <= n_status;
            r_rslot  <= n_rslot;
            r_free   <= n_free;
        end
    end

    assign o_stat.busy      = (r_state != ST_IDLE);
    assign o_stat.count     = r_count;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_result_slot    = r_rslot;
    assign o_slot_is_free   = r_free;
    assign o_occupied_count = r_count;

endmodule
`default_nettype wire

### design/slot_table_first_free_oldest_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_table_first_free_oldest_unit
// Slot table of dated entries with first-free insert and oldest-date query.
// ----------------------------------------------------------------------------
// Set, delete, clear-all, query-free and unused operation codes register
// their result at the accept edge. For insert and the oldest query the search
// travels through the chain of slot cells one cell per cycle, and the
// sequencer waits for it to leave the last cell before it writes the free
// slot or reports the oldest one. One result register sits on the output; a
// new transaction is taken only while the sequencer is idle, and then as long
// as the result register is empty or the downstream side takes its result in
// the same cycle.
module slot_table_first_free_oldest_unit #(
    parameter int SLOTS = stffo_pkg::SlotsDef
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [stffo_pkg::OpW-1:0]      i_operation,
    input  wire  [stffo_pkg::SlotNumW-1:0] i_slot_number,
    input  wire  [stffo_pkg::YearW-1:0]    i_date_year,
    input  wire  [stffo_pkg::MonthW-1:0]   i_date_month,
    input  wire  [stffo_pkg::DayW-1:0]     i_date_day,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [stffo_pkg::StatusW-1:0]  o_status,
    output logic [stffo_pkg::SlotNumW-1:0] o_result_slot,
    output logic                           o_slot_is_free,
    output logic [stffo_pkg::CountW-1:0]   o_occupied_count
);
    import stffo_pkg::*;

    t_scan            w_scan [SLOTS+1];
    logic [SLOTS-1:0] w_valid;
    t_cmd             w_cmd;
    t_ctrl_stat       w_stat;
    logic [DateW-1:0] w_key;

    assign w_key     = {i_date_year, i_date_month, i_date_day};
    assign w_scan[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        stffo_cell #(
            .CELL_NUM(6'(g + 1))
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (w_cmd),
            .i_scan (w_scan[g]),
            .o_scan (w_scan[g+1]),
            .o_valid(w_valid[g])
        );
    end

    stffo_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_slot_number   (i_slot_number),
        .i_key           (w_key),
        .i_valid_vec     (w_valid),
        .i_tail          (w_scan[SLOTS]),
        .o_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_result_slot   (o_result_slot),
        .o_slot_is_free  (o_slot_is_free),
        .o_occupied_count(o_occupied_count)
    );

`ifndef ASSERT_OFF
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(w_stat.count))
        else $error("occupied count differs from valid bits");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !o_in_ready)
        else $error("input ready while a search is running");

    a_result_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_result_slot) <= SLOTS))
        else $error("result slot beyond table");
`endif

endmodule
`default_nettype wire
